// ----- src/mhq_pkg.sv -----
package mhq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CHANGE = 3'd3,
    OP_DUMP   = 3'd4,
    OP_NOP    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] id;
    logic [15:0] prio;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] prio;
  } entry_t;

endpackage

// ----- src/min_heap_job_queue_core.sv -----
// Binary min-heap job queue of up to 64 entries (16-bit id, signed 16-bit priority, lower is
// more urgent) kept in a single-port-write, registered-read memory. A two-item command queue
// decouples input from the heap engine, and a result register decouples the engine from the
// output. The engine reads at most one memory word per cycle. Peek reads the root; insert
// climbs level by level from the end; pop reads the root and the last entry, then descends
// (at most 5 levels); change priority scans in order for the matching id, then sifts it;
// dump emits every entry in turn. Status codes: 0 ok, 1 empty, 2 id not found, 3 full.
module min_heap_job_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] job_id, [31:16] priority_in
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [15:0] job_id_out, [31:16] priority_out
  output logic [1:0]  m_axis_tuser_o,  // [1:0] status
  output logic        m_axis_tlast_o
);

  logic          cmd_valid, cmd_ready;
  mhq_pkg::cmd_t cmd;

  mhq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[15:0]),
    .in_prio_i   (s_axis_tdata_i[31:16]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mhq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_id_o     (m_axis_tdata_o[15:0]),
    .out_prio_o   (m_axis_tdata_o[31:16]),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ----- src/mhq_front.sv -----
module mhq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_func_i,
  input  logic [15:0]   in_id_i,
  input  logic [15:0]   in_prio_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mhq_pkg::cmd_t cmd_o
);

  mhq_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;
  mhq_pkg::cmd_t cmd_in;
  logic          push, pop;

  always_comb begin
    cmd_in.id   = in_id_i;
    cmd_in.prio = in_prio_i;
    unique case (in_func_i)
      mhq_pkg::OP_INSERT: cmd_in.op = mhq_pkg::OP_INSERT;
      mhq_pkg::OP_POP:    cmd_in.op = mhq_pkg::OP_POP;
      mhq_pkg::OP_PEEK:   cmd_in.op = mhq_pkg::OP_PEEK;
      mhq_pkg::OP_CHANGE: cmd_in.op = mhq_pkg::OP_CHANGE;
      mhq_pkg::OP_DUMP:   cmd_in.op = mhq_pkg::OP_DUMP;
      default:            cmd_in.op = mhq_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/mhq_back.sv -----
module mhq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  mhq_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   out_id_o,
  output logic [15:0]   out_prio_o,
  output logic [1:0]    out_status_o,
  output logic          out_last_o
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_POP0 = 15'b000000000000010,
    S_POP1 = 15'b000000000000100,
    S_POP2 = 15'b000000000001000,
    S_PEEK = 15'b000000000010000,
    S_SRD  = 15'b000000000100000,
    S_SCMP = 15'b000000001000000,
    S_UP   = 15'b000000010000000,
    S_UPC  = 15'b000000100000000,
    S_DN   = 15'b000001000000000,
    S_DNL  = 15'b000010000000000,
    S_DNR  = 15'b000100000000000,
    S_DRD  = 15'b001000000000000,
    S_DEM  = 15'b010000000000000,
    S_EMIT = 15'b100000000000000
  } state_e;

  localparam int unsigned AW = mhq_pkg::AddrW;
  localparam int unsigned CW = mhq_pkg::CountW;

  mhq_pkg::entry_t mem [mhq_pkg::Capacity];
  mhq_pkg::entry_t rdata_q, wdata, cur_q, cur_d, lch_q, lch_d, res_q, res_d;
  logic [AW-1:0]   raddr, waddr;
  logic            re, we;

  state_e           state_q, state_d;
  mhq_pkg::cmd_t    cmd_q, cmd_d;
  mhq_pkg::status_e st_q, st_d;
  logic [CW-1:0]    cnt_q, cnt_d, idx_q, idx_d;
  logic [CW:0]      lidx, ridx;
  logic [CW-1:0]    pidx;

  logic            ov_q;
  mhq_pkg::entry_t od_q;
  logic [1:0]      ost_q;
  logic            olast_q;
  logic            out_free, ld;
  mhq_pkg::entry_t ld_data;
  logic            ld_last;

  assign lidx     = {idx_q, 1'b1};
  assign ridx     = lidx + 1'b1;
  assign pidx     = (idx_q - 1'b1) >> 1;
  assign out_free = !ov_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    st_d    = st_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    lch_d   = lch_q;
    res_d   = res_q;
    re      = 1'b0;
    raddr   = idx_q[AW-1:0];
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = cur_q;
    ld      = 1'b0;
    ld_data = res_q;
    ld_last = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          st_d  = mhq_pkg::ST_OK;
          res_d = '0;
          idx_d = '0;
          unique case (cmd_i.op)
            mhq_pkg::OP_INSERT: begin
              if (cnt_q == CW'(mhq_pkg::Capacity)) begin
                st_d    = mhq_pkg::ST_FULL;
                state_d = S_EMIT;
              end else begin
                cur_d   = '{id: cmd_i.id, prio: cmd_i.prio};
                idx_d   = cnt_q;
                cnt_d   = cnt_q + 1'b1;
                state_d = S_UP;
              end
            end
            mhq_pkg::OP_POP, mhq_pkg::OP_PEEK, mhq_pkg::OP_DUMP: begin
              if (cnt_q == '0) begin
                st_d    = mhq_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else if (cmd_i.op == mhq_pkg::OP_DUMP) begin
                state_d = S_DRD;
              end else begin
                re      = 1'b1;
                raddr   = '0;
                state_d = (cmd_i.op == mhq_pkg::OP_POP) ? S_POP1 : S_PEEK;
              end
            end
            mhq_pkg::OP_CHANGE: state_d = S_SRD;
            default:            state_d = S_EMIT;
          endcase
        end
      end
      S_PEEK: begin
        res_d   = rdata_q;
        state_d = S_EMIT;
      end
      S_POP1: begin
        res_d = rdata_q;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = AW'(cnt_q - 1'b1);
          state_d = S_POP2;
        end
      end
      S_POP2: begin
        cur_d   = rdata_q;
        idx_d   = '0;
        state_d = S_DN;
      end
      S_SRD: begin
        if (idx_q >= cnt_q) begin
          st_d    = mhq_pkg::ST_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (rdata_q.id == cmd_q.id) begin
          cur_d   = '{id: rdata_q.id, prio: cmd_q.prio};
          state_d = ($signed(cmd_q.prio) < $signed(rdata_q.prio)) ? S_UP : S_DN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_UP: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = pidx[AW-1:0];
          state_d = S_UPC;
        end
      end
      S_UPC: begin
        we = 1'b1;
        if ($signed(cur_q.prio) < $signed(rdata_q.prio)) begin
          wdata   = rdata_q;
          idx_d   = pidx;
          state_d = S_UP;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DN: begin
        if (lidx >= {1'b0, cnt_q}) begin
          we      = 1'b1;
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = lidx[AW-1:0];
          state_d = S_DNL;
        end
      end
      S_DNL: begin
        lch_d = rdata_q;
        if (ridx < {1'b0, cnt_q}) begin
          re      = 1'b1;
          raddr   = ridx[AW-1:0];
          state_d = S_DNR;
        end else begin
          we = 1'b1;
          if ($signed(rdata_q.prio) < $signed(cur_q.prio)) begin
            wdata   = rdata_q;
            idx_d   = lidx[CW-1:0];
            state_d = S_DN;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DNR: begin
        we = 1'b1;
        if ($signed(rdata_q.prio) < $signed(lch_q.prio)) begin
          if ($signed(rdata_q.prio) < $signed(cur_q.prio)) begin
            wdata   = rdata_q;
            idx_d   = ridx[CW-1:0];
            state_d = S_DN;
          end else begin
            state_d = S_EMIT;
          end
        end else if ($signed(lch_q.prio) < $signed(cur_q.prio)) begin
          wdata   = lch_q;
          idx_d   = lidx[CW-1:0];
          state_d = S_DN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DRD: begin
        re      = 1'b1;
        state_d = S_DEM;
      end
      S_DEM: begin
        ld_data = rdata_q;
        ld_last = (idx_q + 1'b1 == cnt_q);
        if (out_free) begin
          ld      = 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = ld_last ? S_IDLE : S_DRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cur_q <= cur_d;
    lch_q <= lch_d;
    res_q <= res_d;
    if (ld) begin
      od_q    <= ld_data;
      ost_q   <= st_q;
      olast_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= mhq_pkg::ST_OK;
      cnt_q   <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (ld) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_id_o     = od_q.id;
  assign out_prio_o   = od_q.prio;
  assign out_status_o = ost_q;
  assign out_last_o   = olast_q;

endmodule

// ----- src/mhq_checker.sv -----
module mhq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output item changed.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != mhq_pkg::ST_OK |-> m_axis_tdata_o == '0)
    else $error("Error item carries data.");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != mhq_pkg::ST_OK |-> m_axis_tlast_o)
    else $error("Error item is not the last of its command.");

  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("Output valid right after reset.");

endmodule

bind min_heap_job_queue_core mhq_checker u_mhq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
